>>> rtl/wss_pkg.sv
package wss_pkg;

   localparam int CHANNELS    = 2;
   localparam int POINTS      = 8;
   localparam int AUX_ROWS    = 3;
   localparam int ROWS        = 7 + AUX_ROWS;
   localparam int HOLIDAYS    = 8;
   localparam int SEARCH_DAYS = 7;

   localparam int PT_DEPTH  = CHANNELS * ROWS * POINTS;
   localparam int PT_ADDR_W = $clog2(PT_DEPTH);
   localparam int ROW_W     = 4;
   localparam int PIDX_W    = $clog2(POINTS);
   localparam int HIDX_W    = $clog2(HOLIDAYS);
   localparam int DAY_W     = 3;
   localparam int TIME_W    = 11;

   localparam logic [15:0]       NO_TIME   = 16'hFFFF;
   localparam logic [7:0]        UNUSED_DM = 8'hFF;
   localparam logic [TIME_W-1:0] LAST_MIN  = TIME_W'(23 * 60 + 59);

   localparam logic REG_IGNORE  = 1'b0;
   localparam logic REG_DEFAULT = 1'b1;

   typedef enum logic [1:0] {
      MODE_POINT   = 2'd0,
      MODE_HOLIDAY = 2'd1,
      MODE_REPEAT  = 2'd2,
      MODE_EVAL    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DAY,
      ST_ADDR,
      ST_CMP,
      ST_STEP,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic write;
      logic set_default;
      logic day_setup;
      logic dec_point;
      logic hit;
      logic miss;
      logic step_day;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_eval;
      logic time_bad;
      logic hit;
      logic point_zero;
      logic last_day;
      logic out_free;
   } status_type;

   function automatic logic [7:0] month_len(input logic [7:0] mon);
      logic [7:0] len;
      len = 8'd31;
      unique case (mon)
         8'd2:                        len = 8'd28;
         8'd4, 8'd6, 8'd9, 8'd11:     len = 8'd30;
         default:                     len = 8'd31;
      endcase
      return len;
   endfunction

   function automatic logic [PT_ADDR_W-1:0] point_addr(input logic ch,
                                                       input logic [ROW_W-1:0] row,
                                                       input logic [PIDX_W-1:0] pt);
      return PT_ADDR_W'(int'(ch) * ROWS * POINTS + int'(row) * POINTS + int'(pt));
   endfunction

endpackage

>>> rtl/wss_req_if.sv
interface wss_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic        channel;
   logic [3:0]  entry_row;
   logic [2:0]  point_index;
   logic [15:0] entry_value;
   logic        time_ok;
   logic [2:0]  weekday;
   logic [7:0]  month_day;
   logic [7:0]  month_number;
   logic [1:0]  year_mod_four;
   logic [4:0]  hour_now;
   logic [5:0]  minute_now;

   modport source (output valid, mode, channel, entry_row, point_index, entry_value,
                   time_ok, weekday, month_day, month_number, year_mod_four,
                   hour_now, minute_now, input ready);
   modport sink (input valid, mode, channel, entry_row, point_index, entry_value,
                 time_ok, weekday, month_day, month_number, year_mod_four,
                 hour_now, minute_now, output ready);
endinterface

>>> rtl/wss_rsp_if.sv
interface wss_rsp_if;
   logic              valid;
   logic              ready;
   logic              output_on;
   logic signed [4:0] found_row;
   logic signed [3:0] found_point;
   logic signed [3:0] holiday_hit;

   modport source (output valid, output_on, found_row, found_point, holiday_hit,
                   input ready);
   modport sink (input valid, output_on, found_row, found_point, holiday_hit,
                 output ready);
endinterface

>>> rtl/weekly_schedule_switch.sv
// channel   direction  handshake        payload
// req_bus   in         valid/ready      mode, channel, entry fields, date and time
// rsp_bus   out        valid/ready      output_on, found_row, found_point, holiday_hit
// csr_*     in         APB write/read   ignore_time_mask (0x0), default_on_mask (0x4)
//
// Write words and invalid-time evaluates pass through decode and finish to reach the output register.
// An evaluate sets up each day, then reads and compares its points from the last one down;
// it steps back a day when none hits, over at most 7 days.
// Each point costs a point-table read and a compare.
// Synchronous reset clears control, the holiday and repeat tables and the valid bits.
// A new word is taken once the previous result is in the output register.
module weekly_schedule_switch (
   input  logic              clock,
   input  logic              reset,
   wss_req_if.sink           req_bus,
   wss_rsp_if.source         rsp_bus,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   wss_pkg::cmd_type    cmd;
   wss_pkg::status_type status;
   logic [4:0]          out_row;
   logic [3:0]          out_point, out_hol;

   wss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wss_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_mode          (req_bus.mode),
      .in_channel       (req_bus.channel),
      .in_entry_row     (req_bus.entry_row),
      .in_point_index   (req_bus.point_index),
      .in_entry_value   (req_bus.entry_value),
      .in_time_ok       (req_bus.time_ok),
      .in_weekday       (req_bus.weekday),
      .in_month_day     (req_bus.month_day),
      .in_month_number  (req_bus.month_number),
      .in_year_mod_four (req_bus.year_mod_four),
      .in_hour_now      (req_bus.hour_now),
      .in_minute_now    (req_bus.minute_now),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .out_on           (rsp_bus.output_on),
      .out_row          (out_row),
      .out_point        (out_point),
      .out_hol          (out_hol),
      .psel             (csr_psel),
      .penable          (csr_penable),
      .pwrite           (csr_pwrite),
      .paddr            (csr_paddr),
      .pwdata           (csr_pwdata),
      .prdata           (csr_prdata)
   );

   assign rsp_bus.found_row   = signed'(out_row);
   assign rsp_bus.found_point = signed'(out_point);
   assign rsp_bus.holiday_hit = signed'(out_hol);
   assign csr_pready          = 1'b1;
endmodule

>>> rtl/wss_ram.sv
module wss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 160
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/wss_ctrl.sv
module wss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wss_pkg::status_type  status,
   output wss_pkg::cmd_type     cmd
);
   wss_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         wss_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = wss_pkg::ST_DECODE;
            end
         end
         wss_pkg::ST_DECODE: begin
            priority if (!status.is_eval) begin
               cmd.write = 1'b1;
               state_in  = wss_pkg::ST_FINISH;
            end else if (status.time_bad) begin
               cmd.set_default = 1'b1;
               state_in        = wss_pkg::ST_FINISH;
            end else begin
               state_in = wss_pkg::ST_DAY;
            end
         end
         wss_pkg::ST_DAY: begin
            cmd.day_setup = 1'b1;
            state_in      = wss_pkg::ST_ADDR;
         end
         wss_pkg::ST_ADDR: begin
            state_in = wss_pkg::ST_CMP;
         end
         wss_pkg::ST_CMP: begin
            priority if (status.hit) begin
               cmd.hit  = 1'b1;
               state_in = wss_pkg::ST_FINISH;
            end else if (status.point_zero) begin
               state_in = wss_pkg::ST_STEP;
            end else begin
               cmd.dec_point = 1'b1;
               state_in      = wss_pkg::ST_ADDR;
            end
         end
         wss_pkg::ST_STEP: begin
            if (status.last_day) begin
               cmd.miss = 1'b1;
               state_in = wss_pkg::ST_FINISH;
            end else begin
               cmd.step_day = 1'b1;
               state_in     = wss_pkg::ST_DAY;
            end
         end
         wss_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = wss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wss_pkg::ST_IDLE;
         end
      endcase
   end
endmodule

>>> rtl/wss_dp.sv
module wss_dp (
   input  logic                clock,
   input  logic                reset,
   input  wss_pkg::cmd_type    cmd,
   output wss_pkg::status_type status,
   input  logic [1:0]          in_mode,
   input  logic                in_channel,
   input  logic [3:0]          in_entry_row,
   input  logic [2:0]          in_point_index,
   input  logic [15:0]         in_entry_value,
   input  logic                in_time_ok,
   input  logic [2:0]          in_weekday,
   input  logic [7:0]          in_month_day,
   input  logic [7:0]          in_month_number,
   input  logic [1:0]          in_year_mod_four,
   input  logic [4:0]          in_hour_now,
   input  logic [5:0]          in_minute_now,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                out_on,
   output logic [4:0]          out_row,
   output logic [3:0]          out_point,
   output logic [3:0]          out_hol,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata
);
   localparam int RW = wss_pkg::ROW_W;

   logic [1:0]                  mode_ff;
   logic                        ch_ff;
   logic [3:0]                  erow_ff;
   logic [2:0]                  pidx_ff;
   logic [15:0]                 val_ff;
   logic                        tok_ff;
   logic [2:0]                  wd_ff;
   logic [7:0]                  mday_ff, mon_ff;
   logic [1:0]                  yr_ff;
   logic [wss_pkg::TIME_W-1:0]  tnow_ff;
   logic [RW-1:0]               row_ff;
   logic [3:0]                  hol_ff;
   logic [wss_pkg::PIDX_W-1:0]  pt_ff;
   logic [wss_pkg::DAY_W-1:0]   day_ff;
   logic                        res_on_ff;
   logic [4:0]                  res_row_ff;
   logic [3:0]                  res_pt_ff, res_hol_ff;
   logic                        rsp_valid_ff, out_on_ff;
   logic [4:0]                  out_row_ff;
   logic [3:0]                  out_pt_ff, out_hol_ff;
   logic [7:0]                  hday_ff [wss_pkg::HOLIDAYS];
   logic [7:0]                  hmon_ff [wss_pkg::HOLIDAYS];
   logic [7:0]                  hrow_ff [wss_pkg::HOLIDAYS];
   logic [wss_pkg::ROWS-1:0]    rep_ff [wss_pkg::CHANNELS];
   logic [wss_pkg::CHANNELS-1:0] state_ff, ignore_ff, default_ff;
   logic [wss_pkg::PT_DEPTH-1:0] pvalid_ff;
   logic                        rvalid_ff;

   logic                          hmatch;
   logic [wss_pkg::HIDX_W-1:0]    hidx;
   logic [RW-1:0]                 base_row, eff_row;
   logic [7:0]                    nmon, nmday;
   logic [1:0]                    nyr;
   logic [15:0]                   rdata, ptime;
   logic [wss_pkg::PT_ADDR_W-1:0] raddr, waddr;
   logic                          pt_we, csr_we;

   assign raddr = wss_pkg::point_addr(ch_ff, row_ff, pt_ff);
   assign waddr = wss_pkg::point_addr(ch_ff, erow_ff, pidx_ff);
   assign pt_we = cmd.write && (mode_ff == wss_pkg::MODE_POINT)
                  && (int'(erow_ff) < wss_pkg::ROWS);

   wss_ram #(.WIDTH(16), .DEPTH(wss_pkg::PT_DEPTH)) u_ram (
      .clock (clock),
      .we    (pt_we),
      .waddr (waddr),
      .wdata (val_ff),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign ptime = rvalid_ff ? rdata : wss_pkg::NO_TIME;

   always_comb begin
      hmatch = 1'b0;
      hidx   = '0;
      for (int h = wss_pkg::HOLIDAYS - 1; h >= 0; h--) begin
         if (hday_ff[h] != wss_pkg::UNUSED_DM && hmon_ff[h] != wss_pkg::UNUSED_DM
             && mday_ff == hday_ff[h] && mon_ff == hmon_ff[h]
             && int'(hrow_ff[h]) < wss_pkg::ROWS) begin
            hmatch = 1'b1;
            hidx   = wss_pkg::HIDX_W'(h);
         end
      end
      base_row = hmatch ? RW'(hrow_ff[hidx])
                        : ((wd_ff != 3'd0) ? RW'(wd_ff - 3'd1) : RW'(6));
      eff_row = '0;
      for (int j = 0; j < wss_pkg::ROWS; j++) begin
         if (RW'(j) <= base_row && (j == 0 || !rep_ff[ch_ff][j])) begin
            eff_row = RW'(j);
         end
      end
   end

   always_comb begin
      nmon  = mon_ff;
      nyr   = yr_ff;
      nmday = mday_ff - 8'd1;
      if (mday_ff <= 8'd1) begin
         if (mon_ff <= 8'd1) begin
            nmon = 8'd12;
            nyr  = yr_ff - 2'd1;
         end else begin
            nmon = mon_ff - 8'd1;
         end
         nmday = wss_pkg::month_len(nmon);
         if (nmday == 8'd28 && nyr == 2'd0) begin
            nmday = 8'd29;
         end
      end
   end

   assign status.is_eval    = (mode_ff == wss_pkg::MODE_EVAL);
   assign status.time_bad   = !tok_ff && !ignore_ff[ch_ff];
   assign status.hit        = (ptime != wss_pkg::NO_TIME) && (ptime <= 16'(tnow_ff));
   assign status.point_zero = (pt_ff == '0);
   assign status.last_day   = (int'(day_ff) == wss_pkg::SEARCH_DAYS - 1);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign csr_we = psel && penable && pwrite;
   assign prdata = {30'b0, (paddr[2] == wss_pkg::REG_DEFAULT) ? default_ff : ignore_ff};

   always_ff @(posedge clock) begin
      rvalid_ff <= pvalid_ff[raddr];
      if (cmd.load) begin
         mode_ff <= in_mode;
         ch_ff   <= in_channel;
         erow_ff <= in_entry_row;
         pidx_ff <= in_point_index;
         val_ff  <= in_entry_value;
         tok_ff  <= in_time_ok;
         wd_ff   <= (in_weekday > 3'd6) ? 3'd0 : in_weekday;
         mday_ff <= in_month_day;
         mon_ff  <= in_month_number;
         yr_ff   <= in_year_mod_four;
         tnow_ff <= wss_pkg::TIME_W'(in_hour_now) * wss_pkg::TIME_W'(60)
                    + wss_pkg::TIME_W'(in_minute_now);
         day_ff  <= '0;
      end
      if (cmd.day_setup) begin
         row_ff <= eff_row;
         hol_ff <= hmatch ? 4'(hidx) : 4'hF;
         pt_ff  <= wss_pkg::PIDX_W'(wss_pkg::POINTS - 1);
      end
      if (cmd.dec_point) begin
         pt_ff <= pt_ff - 1'b1;
      end
      if (cmd.step_day) begin
         day_ff  <= day_ff + 1'b1;
         wd_ff   <= (wd_ff == 3'd0) ? 3'd6 : wd_ff - 3'd1;
         mday_ff <= nmday;
         mon_ff  <= nmon;
         yr_ff   <= nyr;
         tnow_ff <= wss_pkg::LAST_MIN;
      end
      if (cmd.write) begin
         res_on_ff  <= state_ff[ch_ff];
         res_row_ff <= 5'h1F;
         res_pt_ff  <= 4'hF;
         res_hol_ff <= 4'hF;
      end
      if (cmd.set_default) begin
         res_on_ff  <= default_ff[ch_ff];
         res_row_ff <= 5'h1F;
         res_pt_ff  <= 4'hF;
         res_hol_ff <= 4'hF;
      end
      if (cmd.hit) begin
         res_on_ff  <= ~pt_ff[0];
         res_row_ff <= 5'(row_ff);
         res_pt_ff  <= 4'(pt_ff);
         res_hol_ff <= hol_ff;
      end
      if (cmd.miss) begin
         res_on_ff  <= 1'b0;
         res_row_ff <= 5'h1F;
         res_pt_ff  <= 4'hF;
         res_hol_ff <= hol_ff;
      end
      if (cmd.emit) begin
         out_on_ff  <= res_on_ff;
         out_row_ff <= res_row_ff;
         out_pt_ff  <= res_pt_ff;
         out_hol_ff <= res_hol_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         ignore_ff    <= '0;
         default_ff   <= '0;
         pvalid_ff    <= '0;
         for (int h = 0; h < wss_pkg::HOLIDAYS; h++) begin
            hday_ff[h] <= wss_pkg::UNUSED_DM;
            hmon_ff[h] <= wss_pkg::UNUSED_DM;
            hrow_ff[h] <= '0;
         end
         for (int c = 0; c < wss_pkg::CHANNELS; c++) begin
            rep_ff[c] <= '0;
         end
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            if (paddr[2] == wss_pkg::REG_DEFAULT) begin
               default_ff <= pwdata[1:0];
            end else begin
               ignore_ff <= pwdata[1:0];
            end
         end
         if (pt_we) begin
            pvalid_ff[waddr] <= 1'b1;
         end
         if (cmd.write && mode_ff == wss_pkg::MODE_HOLIDAY
             && int'(erow_ff) < wss_pkg::HOLIDAYS) begin
            hday_ff[erow_ff[wss_pkg::HIDX_W-1:0]] <= mday_ff;
            hmon_ff[erow_ff[wss_pkg::HIDX_W-1:0]] <= mon_ff;
            hrow_ff[erow_ff[wss_pkg::HIDX_W-1:0]] <= val_ff[7:0];
         end
         if (cmd.write && mode_ff == wss_pkg::MODE_REPEAT) begin
            rep_ff[ch_ff] <= val_ff[wss_pkg::ROWS-1:0];
         end
         if (cmd.set_default) begin
            state_ff[ch_ff] <= default_ff[ch_ff];
         end
         if (cmd.hit) begin
            state_ff[ch_ff] <= ~pt_ff[0];
         end
         if (cmd.miss) begin
            state_ff[ch_ff] <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_on    = out_on_ff;
   assign out_row   = out_row_ff;
   assign out_point = out_pt_ff;
   assign out_hol   = out_hol_ff;
endmodule

>>> rtl/wss_checker.sv
module wss_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("word taken while busy");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("rsp raised while idle");
endmodule

bind weekly_schedule_switch wss_checker u_wss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);

>>> test/tb_weekly_schedule_switch.sv
module tb_weekly_schedule_switch;

   typedef struct {
      logic [1:0]  mode;
      logic        channel;
      logic [3:0]  entry_row;
      logic [2:0]  point_index;
      logic [15:0] entry_value;
      logic        time_ok;
      logic [2:0]  weekday;
      logic [7:0]  month_day;
      logic [7:0]  month_number;
      logic [1:0]  year_mod_four;
      logic [4:0]  hour_now;
      logic [5:0]  minute_now;
   } word_type;

   typedef struct {
      logic              output_on;
      logic signed [4:0] found_row;
      logic signed [3:0] found_point;
      logic signed [3:0] holiday_hit;
   } result_type;

   typedef struct {
      word_type   w;
      logic       known;
      result_type r;
   } dir_row_type;

   typedef struct {
      result_type r;
      logic       known;
      result_type typed;
   } pending_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   wss_req_if req_bus ();
   wss_rsp_if rsp_bus ();

   weekly_schedule_switch u_top (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   logic [15:0] sched_points [wss_pkg::CHANNELS][wss_pkg::ROWS][wss_pkg::POINTS];
   logic [7:0]  hol_day [wss_pkg::HOLIDAYS];
   logic [7:0]  hol_mon [wss_pkg::HOLIDAYS];
   logic [7:0]  hol_row [wss_pkg::HOLIDAYS];
   logic [wss_pkg::ROWS-1:0] repeat_mask [wss_pkg::CHANNELS];
   logic        switch_on [wss_pkg::CHANNELS];
   logic [1:0]  ignore_mask, default_mask;

   pending_type expected_results[$];
   int  mismatches = 0;
   int  accepted_words = 0, evaluates_seen = 0, results_seen = 0;
   int  idle_cycles = 0;
   bit  quiet = 0;
   bit  long_hold = 0;
   logic       cur_known = 0;
   result_type cur_typed;

   task automatic report(input string what, input int got, input int exp);
      $display("MISMATCH %s: got %0d expected %0d at result %0d",
               what, got, exp, results_seen);
      mismatches++;
   endtask

   function automatic result_type mk(input logic on, input int row, input int pt,
                                     input int hol);
      result_type r;
      r.output_on = on;
      r.found_row = row[4:0];
      r.found_point = pt[3:0];
      r.holiday_hit = hol[3:0];
      return r;
   endfunction

   function automatic result_type switch_state_for(input word_type w);
      int unsigned wd, mday, mon, yr, tnow, row, st;
      int found_pt, found_row, hol;
      found_pt = -1; found_row = -1; hol = -1; st = 0;
      case (wss_pkg::mode_type'(w.mode))
         wss_pkg::MODE_POINT: if (int'(w.entry_row) < wss_pkg::ROWS)
            sched_points[w.channel][w.entry_row][w.point_index] = w.entry_value;
         wss_pkg::MODE_HOLIDAY: if (int'(w.entry_row) < wss_pkg::HOLIDAYS) begin
            hol_day[w.entry_row] = w.month_day;
            hol_mon[w.entry_row] = w.month_number;
            hol_row[w.entry_row] = w.entry_value[7:0];
         end
         wss_pkg::MODE_REPEAT: repeat_mask[w.channel] = w.entry_value[wss_pkg::ROWS-1:0];
         default: ;
      endcase
      if (w.mode != wss_pkg::MODE_EVAL) return mk(switch_on[w.channel], -1, -1, -1);
      if (!w.time_ok && !ignore_mask[w.channel]) begin
         switch_on[w.channel] = default_mask[w.channel];
         return mk(switch_on[w.channel], -1, -1, -1);
      end
      wd = w.weekday > 3'd6 ? 0 : 32'(w.weekday);
      mday = 32'(w.month_day); mon = 32'(w.month_number); yr = 32'(w.year_mod_four);
      tnow = 32'(w.hour_now) * 60 + 32'(w.minute_now);
      for (int d = 0; d < wss_pkg::SEARCH_DAYS; d++) begin
         row = wd > 0 ? wd - 1 : 6;
         hol = -1;
         for (int h = 0; h < wss_pkg::HOLIDAYS; h++)
            if (hol_day[h] != wss_pkg::UNUSED_DM && hol_mon[h] != wss_pkg::UNUSED_DM &&
                mday == 32'(hol_day[h]) && mon == 32'(hol_mon[h]) &&
                int'(hol_row[h]) < wss_pkg::ROWS) begin
               row = 32'(hol_row[h]);
               hol = h;
               break;
            end
         while (row > 0 && repeat_mask[w.channel][row]) row--;
         for (int p = wss_pkg::POINTS - 1; p >= 0; p--)
            if (sched_points[w.channel][row][p] != wss_pkg::NO_TIME &&
                32'(sched_points[w.channel][row][p]) <= tnow) begin
               found_pt = p;
               break;
            end
         if (found_pt >= 0) begin
            found_row = int'(row);
            st = 32'((found_pt & 1) ^ 1);
            break;
         end
         wd = wd == 0 ? 6 : wd - 1;
         if (mday <= 1) begin
            if (mon <= 1) begin
               mon = 12;
               yr = (yr - 1) & 3;
            end else begin
               mon = mon - 1;
            end
            mday = (mon >= 1 && mon <= 12) ? 32'(wss_pkg::month_len(mon[7:0])) : 31;
            if (mday == 28 && yr == 0) mday = 29;
         end else begin
            mday = mday - 1;
         end
         tnow = 23 * 60 + 59;
      end
      switch_on[w.channel] = st[0];
      return mk(st[0], found_row, found_pt, hol);
   endfunction

   task automatic reset_schedule();
      foreach (sched_points[c, r, p]) sched_points[c][r][p] = wss_pkg::NO_TIME;
      foreach (hol_day[h]) begin
         hol_day[h] = wss_pkg::UNUSED_DM;
         hol_mon[h] = wss_pkg::UNUSED_DM;
         hol_row[h] = 0;
      end
      foreach (repeat_mask[c]) begin
         repeat_mask[c] = 0;
         switch_on[c] = 0;
      end
      ignore_mask = 0;
      default_mask = 0;
   endtask

   task automatic csr_write(input logic idx, input logic [1:0] value);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= 3'(idx) << 2; csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      if (csr_prdata[1:0] !== value) report("csr readback", int'(csr_prdata[1:0]), int'(value));
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx == wss_pkg::REG_IGNORE) ignore_mask = value; else default_mask = value;
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   // drive one word; idle randomly beforehand
   task automatic send_word(input word_type w);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.mode <= w.mode; req_bus.channel <= w.channel;
      req_bus.entry_row <= w.entry_row; req_bus.point_index <= w.point_index;
      req_bus.entry_value <= w.entry_value; req_bus.time_ok <= w.time_ok;
      req_bus.weekday <= w.weekday; req_bus.month_day <= w.month_day;
      req_bus.month_number <= w.month_number; req_bus.year_mod_four <= w.year_mod_four;
      req_bus.hour_now <= w.hour_now; req_bus.minute_now <= w.minute_now;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   function automatic word_type rand_word();
      word_type w;
      w.mode = $urandom_range(0, 9) < 4 ? wss_pkg::MODE_POINT :
               ($urandom_range(0, 9) < 2 ? 2'($urandom_range(1, 2)) : wss_pkg::MODE_EVAL);
      w.channel = 1'($urandom);
      w.entry_row = $urandom_range(0, 9) == 0 ? 4'($urandom)
                                              : 4'($urandom_range(0, wss_pkg::ROWS - 1));
      w.point_index = 3'($urandom);
      case ($urandom_range(0, 3))
         0: w.entry_value = wss_pkg::NO_TIME;
         1: w.entry_value = 16'($urandom);
         default: w.entry_value = 16'($urandom_range(0, 1439));
      endcase
      if (w.mode == wss_pkg::MODE_HOLIDAY)
         w.entry_value = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                  : 16'($urandom_range(0, wss_pkg::ROWS - 1));
      if (w.mode == wss_pkg::MODE_REPEAT && $urandom_range(0, 1))
         w.entry_value = 16'($urandom_range(0, 255));
      w.time_ok = $urandom_range(0, 7) != 0;
      w.weekday = 3'($urandom);
      w.month_day = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 4));
      w.month_number = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
      w.year_mod_four = 2'($urandom);
      w.hour_now = $urandom_range(0, 15) == 0 ? 5'($urandom) : 5'($urandom_range(0, 23));
      w.minute_now = $urandom_range(0, 15) == 0 ? 6'($urandom) : 6'($urandom_range(0, 59));
      return w;
   endfunction

   function automatic word_type wd_(input logic [1:0] m, input logic ch, input int row,
                                    input int pt, input int val, input logic tok,
                                    input int wday, input int md, input int mn, input int yr,
                                    input int hr, input int mi);
      word_type w;
      w.mode = m; w.channel = ch; w.entry_row = 4'(row); w.point_index = 3'(pt);
      w.entry_value = 16'(val); w.time_ok = tok; w.weekday = 3'(wday);
      w.month_day = 8'(md); w.month_number = 8'(mn); w.year_mod_four = 2'(yr);
      w.hour_now = 5'(hr); w.minute_now = 6'(mi);
      return w;
   endfunction

   dir_row_type directed[$];

   task automatic add(input word_type w, input logic known = 0,
                      input result_type r = '{0, 0, 0, 0});
      dir_row_type d;
      d.w = w; d.known = known; d.r = r;
      directed.push_back(d);
   endtask

   // accept words and queue predictions
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         word_type w;
         pending_type e;
         w.mode = req_bus.mode; w.channel = req_bus.channel;
         w.entry_row = req_bus.entry_row; w.point_index = req_bus.point_index;
         w.entry_value = req_bus.entry_value; w.time_ok = req_bus.time_ok;
         w.weekday = req_bus.weekday; w.month_day = req_bus.month_day;
         w.month_number = req_bus.month_number; w.year_mod_four = req_bus.year_mod_four;
         w.hour_now = req_bus.hour_now; w.minute_now = req_bus.minute_now;
         e.r = switch_state_for(w);
         e.known = cur_known;
         e.typed = cur_typed;
         expected_results.push_back(e);
         accepted_words++;
         if (w.mode == wss_pkg::MODE_EVAL) evaluates_seen++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         pending_type p;
         result_type e;
         if (expected_results.size() == 0) begin
            report("unexpected word", 1, 0);
         end else begin
            p = expected_results.pop_front();
            e = p.known ? p.typed : p.r;
            if (rsp_bus.output_on !== e.output_on)
               report("output_on", rsp_bus.output_on, e.output_on);
            if (rsp_bus.found_row !== e.found_row)
               report("found_row", rsp_bus.found_row, e.found_row);
            if (rsp_bus.found_point !== e.found_point)
               report("found_point", rsp_bus.found_point, e.found_point);
            if (rsp_bus.holiday_hit !== e.holiday_hit)
               report("holiday_hit", rsp_bus.holiday_hit, e.holiday_hit);
         end
         results_seen++;
      end
   end

   // receiver stalls
   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_bus.ready <= 0;
            repeat (400) @(negedge clock);
            long_hold = 0;
            rsp_bus.ready <= 1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("Timeout with %0d results outstanding", expected_results.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      cur_typed = mk(0, -1, -1, -1);
      req_bus.valid = 0;
      {req_bus.mode, req_bus.channel, req_bus.entry_row, req_bus.point_index} = 0;
      {req_bus.entry_value, req_bus.time_ok, req_bus.weekday, req_bus.month_day} = 0;
      {req_bus.month_number, req_bus.year_mod_four, req_bus.hour_now, req_bus.minute_now} = 0;
      reset_schedule();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      add(wd_(wss_pkg::MODE_EVAL, 0, 0, 0, 0, 1, 3, 15, 6, 1, 12, 0), 1, mk(0, -1, -1, -1));
      add(wd_(wss_pkg::MODE_EVAL, 1, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0), 1, mk(0, -1, -1, -1));
      add(wd_(wss_pkg::MODE_POINT, 0, 0, 0, 480, 1, 0, 0, 0, 0, 0, 0), 1, mk(0, -1, -1, -1));
      add(wd_(wss_pkg::MODE_POINT, 0, 0, 7, 1439, 1, 0, 0, 0, 0, 0, 0), 1, mk(0, -1, -1, -1));
      add(wd_(wss_pkg::MODE_POINT, 0, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0));
      add(wd_(wss_pkg::MODE_POINT, 1, 15, 7, 0, 1, 0, 0, 0, 0, 0, 0), 1, mk(0, -1, -1, -1));
      add(wd_(wss_pkg::MODE_EVAL, 0, 0, 0, 0, 1, 1, 10, 3, 1, 8, 0), 1, mk(0, 0, 1, -1));
      add(wd_(wss_pkg::MODE_EVAL, 0, 0, 0, 0, 1, 1, 10, 3, 1, 31, 63), 1, mk(0, 0, 7, -1));
      add(wd_(wss_pkg::MODE_EVAL, 0, 0, 0, 0, 1, 7, 1, 1, 0, 0, 0));
      add(wd_(wss_pkg::MODE_POINT, 0, 9, 2, 600, 1, 0, 0, 0, 0, 0, 0));
      add(wd_(wss_pkg::MODE_HOLIDAY, 0, 0, 0, 9, 1, 0, 1, 1, 0, 0, 0));
      add(wd_(wss_pkg::MODE_HOLIDAY, 0, 1, 0, 200, 1, 0, 2, 1, 0, 0, 0));
      add(wd_(wss_pkg::MODE_HOLIDAY, 1, 15, 0, 3, 1, 0, 3, 3, 0, 0, 0));
      add(wd_(wss_pkg::MODE_EVAL, 0, 0, 0, 0, 1, 4, 1, 1, 0, 12, 0));
      add(wd_(wss_pkg::MODE_EVAL, 0, 0, 0, 0, 1, 4, 2, 1, 0, 1, 0));
      add(wd_(wss_pkg::MODE_REPEAT, 0, 0, 0, 16'hFFFF, 1, 0, 0, 0, 0, 0, 0));
      add(wd_(wss_pkg::MODE_EVAL, 0, 0, 0, 0, 1, 6, 1, 3, 0, 0, 0));
      add(wd_(wss_pkg::MODE_REPEAT, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
      add(wd_(wss_pkg::MODE_EVAL, 0, 0, 0, 0, 1, 2, 0, 0, 2, 0, 0));
      add(wd_(wss_pkg::MODE_EVAL, 0, 0, 0, 0, 1, 2, 255, 255, 3, 0, 0));
      add(wd_(wss_pkg::MODE_EVAL, 0, 0, 0, 0, 1, 5, 1, 13, 3, 0, 0));
      add(wd_(wss_pkg::MODE_EVAL, 1, 0, 0, 0, 1, 2, 1, 3, 0, 0, 0), 1, mk(0, -1, -1, -1));
      foreach (directed[i]) begin
         cur_known = directed[i].known;
         cur_typed = directed[i].r;
         send_word(directed[i].w);
      end
      req_bus.valid <= 0;
      cur_known = 0;
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         csr_write(wss_pkg::REG_IGNORE, phase == 3 ? 2'b11 : 2'(phase));
         csr_write(wss_pkg::REG_DEFAULT, phase == 0 ? 2'b11 : 2'(3 - phase));
         if (phase == 1) long_hold = 1;
         for (int i = 0; i < 250; i++) begin
            quiet = (phase == 3 && i > 150);
            send_word(rand_word());
         end
         req_bus.valid <= 0;
         wait_drained();
      end
      $display("Covered %0d words, %0d evaluates, %0d results over 4 mask settings",
               accepted_words, evaluates_seen, results_seen);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

>>> files.f
rtl/wss_pkg.sv
rtl/wss_req_if.sv
rtl/wss_rsp_if.sv
rtl/wss_ram.sv
rtl/wss_ctrl.sv
rtl/wss_dp.sv
rtl/weekly_schedule_switch.sv
rtl/wss_checker.sv
test/tb_weekly_schedule_switch.sv
